// ----- hdl/lru_pkg.sv -----
`timescale 1ns / 1ps

package lru_pkg;

	localparam int MAX_FRAMES_DEF = 16;

	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic capture;
		logic commit;
	} lru_cmd_t;

endpackage

// ----- hdl/lru_ctrl.sv -----
`timescale 1ns / 1ps

module lru_ctrl
	import lru_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lru_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					// hold the search result until the output register frees up
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/lru_dpath.sv -----
`timescale 1ns / 1ps

module lru_dpath
	import lru_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lru_cmd_t           cmd,
	input  logic               cfg_valid,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               operation,
	input  logic [PAGE_W-1:0]  page,
	output logic               fault,
	output logic [SLOT_W-1:0]  slot,
	output logic               evicted_valid,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [COUNT_W-1:0] fault_count
);

	localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RANK_W = $clog2(MAX_FRAMES + 1);
	localparam logic [RANK_W-1:0] RANK_EMPTY = RANK_W'(MAX_FRAMES);

	// frame state
	logic [PAGE_W-1:0]  page_q  [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [RANK_W-1:0]  rank_q  [MAX_FRAMES];
	logic [COUNT_W-1:0] total_q;
	logic [CFG_W-1:0]   fiu_q;

	// search results, registered at capture
	logic               op_s1;
	logic [PAGE_W-1:0]  page_s1;
	logic               hit_s1;
	logic               empty_s1;
	logic [IDX_W-1:0]   slot_s1;
	logic [RANK_W-1:0]  old_rank_s1;

	// output register
	logic               fault_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               ev_valid_q;
	logic [PAGE_W-1:0]  ev_page_q;
	logic [COUNT_W-1:0] count_q;

	logic [CFG_W-1:0]      fiu_eff;
	logic [MAX_FRAMES-1:0] active;
	logic [MAX_FRAMES-1:0] hit_vec;
	logic [MAX_FRAMES-1:0] empty_vec;
	logic [MAX_FRAMES-1:0] victim_vec;
	logic [IDX_W-1:0]      hit_idx;
	logic [IDX_W-1:0]      empty_idx;
	logic [IDX_W-1:0]      victim_idx;
	logic [IDX_W-1:0]      sel_idx;
	logic                  any_hit;
	logic                  any_empty;
	logic [COUNT_W-1:0]    total_next;
	logic                  evict;

	assign fiu_eff = (fiu_q == '0) ? CFG_W'(1) : fiu_q;

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			active[i]    = (i < int'(fiu_eff));
			hit_vec[i]   = active[i] && valid_q[i] && (page_q[i] == page);
			empty_vec[i] = active[i] && !valid_q[i];
		end
		// the oldest active frame has no active frame ranked above it
		for (int i = 0; i < MAX_FRAMES; i++) begin
			victim_vec[i] = active[i] && valid_q[i];
			for (int j = 0; j < MAX_FRAMES; j++) begin
				if (active[j] && valid_q[j] && (rank_q[j] > rank_q[i])) begin
					victim_vec[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit_idx    = '0;
		empty_idx  = '0;
		victim_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (empty_vec[i]) begin
				empty_idx = IDX_W'(i);
			end
			if (victim_vec[i]) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	assign any_hit   = |hit_vec;
	assign any_empty = |empty_vec;
	assign sel_idx   = any_hit ? hit_idx : (any_empty ? empty_idx : victim_idx);
	assign evict     = !hit_s1 && !empty_s1;
	assign total_next = (total_q == COUNT_MAX) ? total_q : total_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
			total_q <= '0;
			fiu_q   <= FRAMES_RESET;
		end else begin
			if (cfg_valid) begin
				fiu_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (op_s1 == OP_CLEAR) begin
					valid_q <= '0;
					for (int i = 0; i < MAX_FRAMES; i++) begin
						rank_q[i] <= '0;
					end
					total_q <= '0;
				end else begin
					// age every valid frame that was more recent than the promoted one
					for (int i = 0; i < MAX_FRAMES; i++) begin
						if (IDX_W'(i) == slot_s1) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && (rank_q[i] < old_rank_s1)) begin
							rank_q[i] <= rank_q[i] + RANK_W'(1);
						end
					end
					valid_q[slot_s1] <= 1'b1;
					if (!hit_s1) begin
						total_q <= total_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1       <= operation;
			page_s1     <= page;
			hit_s1      <= any_hit;
			empty_s1    <= any_empty;
			slot_s1     <= sel_idx;
			old_rank_s1 <= (any_hit || !any_empty) ? rank_q[sel_idx] : RANK_EMPTY;
		end
		if (cmd.commit) begin
			if (op_s1 == OP_CLEAR) begin
				fault_q    <= 1'b0;
				slot_q     <= '0;
				ev_valid_q <= 1'b0;
				ev_page_q  <= '0;
				count_q    <= '0;
			end else begin
				if (!hit_s1) begin
					page_q[slot_s1] <= page_s1;
				end
				fault_q    <= !hit_s1;
				slot_q     <= SLOT_W'(slot_s1);
				ev_valid_q <= evict;
				ev_page_q  <= evict ? page_q[slot_s1] : '0;
				count_q    <= hit_s1 ? total_q : total_next;
			end
		end
	end

	assign fault         = fault_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = count_q;

endmodule

// ----- hdl/lru_page_replacement_core.sv -----
`timescale 1ns / 1ps

// LRU page replacement core. Holds up to MAX_FRAMES page numbers, fully
// associative, of which the first frames_in_use (written on the cfg channel,
// 0 acts as 1, values above MAX_FRAMES saturate, reset value 16) take part
// in lookup and replacement. Each input transaction is either an access
// (operation = 0) or a clear (operation = 1). An access compares the page
// against every valid frame in use; a hit promotes that frame to most
// recent, a miss loads the page into the lowest empty frame in use, or else
// replaces the least recently used one, and bumps a saturating fault count.
// A clear empties all frames and zeroes the count; its result is all zero.
// Every input transaction yields exactly one output transaction.
// Flow: each item first runs the parallel tag compare and victim search,
// registered at capture, then applies the recency update and loads the
// output register at commit. A new item is accepted only after the previous
// one commits; the commit waits while the previous result is still in the
// output register. Write the configuration only while idle.

module lru_page_replacement_core
	import lru_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [PAGE_W-1:0]  page,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               fault,
	output logic [SLOT_W-1:0]  slot,
	output logic               evicted_valid,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [COUNT_W-1:0] fault_count
);

	lru_cmd_t cmd;

	// the register file takes a write in any cycle
	assign cfg_ready = 1'b1;

	// sequence capture and commit; own the output valid flag
	lru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// frame store, compare, recency ranks, fault counter and output register
	lru_dpath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.operation     (operation),
		.page          (page),
		.fault         (fault),
		.slot          (slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_count   (fault_count)
	);

endmodule
